// ===== src/assert_macros.svh =====
// assertion macros used by the top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mtp_pkg.sv =====
// types, constants and helper functions of the media type parser
// no dependencies
package mtp_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [31:0] TOK_MAP [8] = '{
    32'h0000_0000, 32'h03ff_6800, 32'h87ff_fffe, 32'h07ff_fffe,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  typedef enum logic [2:0] {
    CLS_TOK,
    CLS_SLASH,
    CLS_SEMI,
    CLS_SPACE,
    CLS_EQ,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    PH_TYPE,
    PH_SUB,
    PH_AFTER_SUB,
    PH_NAME_LEAD,
    PH_NAME,
    PH_VAL_START,
    PH_TOKVAL,
    PH_QUOTED,
    PH_ESC,
    PH_AFTER_VAL
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TYPE,
    KIND_SUB,
    KIND_NAME,
    KIND_VALUE
  } kind_t;

  typedef enum logic [3:0] {
    ST_PARSING,
    ST_ACCEPTED,
    ST_EMPTY_TYPE,
    ST_NO_SUBTYPE,
    ST_BAD_TYPE_CHAR,
    ST_EMPTY_SUBTYPE,
    ST_BAD_SUB_CHAR,
    ST_EMPTY_NAME,
    ST_BAD_NAME_CHAR,
    ST_NO_EQUALS,
    ST_EMPTY_VALUE,
    ST_TRUNC_ESC,
    ST_BAD_ESC,
    ST_OPEN_QUOTE,
    ST_BAD_VALUE_CHAR,
    ST_BAD_AFTER_VALUE
  } status_t;

  // one classified item as it travels through the queue
  typedef struct packed {
    logic       term;
    cls_t       cls;
    logic [7:0] raw;
    logic [7:0] low;
  } q_item_t;

  function automatic logic is_tok(input logic [7:0] c);
    logic [31:0] word;
    word = TOK_MAP[c[7:5]];
    return word[c[4:0]];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_DIFF : c;
  endfunction

endpackage

// ===== src/mtp_if.sv =====
// handshake channels of the media type parser
// depends on nothing but plain logic
interface mtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_end;

  modport source (output valid, output in_byte, output is_end, input ready);
  modport sink (input valid, input in_byte, input is_end, output ready);
endinterface

interface mtp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic [1:0] token_kind;
  logic       token_done;
  logic [3:0] status;

  modport source (output valid, output out_char, output char_valid, output token_kind,
                  output token_done, output status, input ready);
  modport sink (input valid, input out_char, input char_valid, input token_kind,
                input token_done, input status, output ready);
endinterface

// ===== src/mtp_front.sv =====
// front end: accepts input items and classifies each byte
// depends on mtp_pkg and mtp_in_if
module mtp_front import mtp_pkg::*; (
  mtp_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      wr_en,
  output q_item_t   wr_item
);

  cls_t cls;

  always_comb begin
    if (is_tok(in_ch.in_byte)) begin
      cls = CLS_TOK;
    end else begin
      unique case (in_ch.in_byte)
        CH_SLASH:  cls = CLS_SLASH;
        CH_SEMI:   cls = CLS_SEMI;
        CH_SPACE:  cls = CLS_SPACE;
        CH_EQ:     cls = CLS_EQ;
        CH_QUOTE:  cls = CLS_QUOTE;
        CH_BSLASH: cls = CLS_BSLASH;
        default:   cls = CLS_OTHER;
      endcase
    end
  end

  assign in_ch.ready  = !q_full;
  assign wr_en        = in_ch.valid && !q_full;
  assign wr_item.term = in_ch.is_end || (in_ch.in_byte == 8'h00);
  assign wr_item.cls  = cls;
  assign wr_item.raw  = in_ch.in_byte;
  assign wr_item.low  = to_lower(in_ch.in_byte);

endmodule

// ===== src/mtp_queue.sv =====
// short queue of classified items between front and back end
// depends on mtp_pkg
module mtp_queue import mtp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  q_item_t wr_item,
  input  logic    rd_en,
  output q_item_t rd_item,
  output logic    q_valid,
  output logic    q_full
);

  q_item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = wr_en ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item = mem_r[rd_ptr_r];
  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));

endmodule

// ===== src/mtp_back.sv =====
// back end: parser state machine and output register
// depends on mtp_pkg and mtp_out_if
module mtp_back import mtp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_item_t   rd_item,
  output logic      rd_en,
  mtp_out_if.source out_ch
);

  phase_t     phase_r, phase_nxt;
  logic       nonempty_r, nonempty_nxt;
  status_t    verdict_r, verdict_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       char_valid_r, char_valid_nxt;
  kind_t      kind_r, kind_nxt;
  logic       done_r, done_nxt;
  status_t    status_r, status_nxt;

  status_t    v;
  logic       put_en, close_en;
  logic [7:0] put_char;
  kind_t      put_kind, close_kind;
  logic       term;
  cls_t       cls;

  assign rd_en = q_valid && (!out_valid_r || out_ch.ready);
  assign term  = rd_item.term;
  assign cls   = rd_item.cls;

  always_comb begin
    phase_nxt  = phase_r;
    v          = verdict_r;
    put_en     = 1'b0;
    put_char   = rd_item.low;
    put_kind   = KIND_TYPE;
    close_en   = 1'b0;
    close_kind = KIND_TYPE;

    if (verdict_r == ST_PARSING) begin
      unique case (phase_r) inside
        PH_TYPE: begin
          if (term) begin
            v = ST_NO_SUBTYPE;
          end else if (cls == CLS_SLASH) begin
            if (!nonempty_r) begin
              v = ST_EMPTY_TYPE;
            end else begin
              close_en  = 1'b1;
              phase_nxt = PH_SUB;
            end
          end else if (cls != CLS_TOK) begin
            v = ST_BAD_TYPE_CHAR;
          end else begin
            put_en = 1'b1;
          end
        end
        PH_SUB: begin
          close_kind = KIND_SUB;
          put_kind   = KIND_SUB;
          if (term || cls == CLS_SEMI || cls == CLS_SPACE) begin
            if (!nonempty_r) begin
              v = ST_EMPTY_SUBTYPE;
            end else begin
              close_en = 1'b1;
              if (term) begin
                v = ST_ACCEPTED;
              end else begin
                phase_nxt = (cls == CLS_SEMI) ? PH_NAME_LEAD : PH_AFTER_SUB;
              end
            end
          end else if (cls != CLS_TOK) begin
            v = ST_BAD_SUB_CHAR;
          end else begin
            put_en = 1'b1;
          end
        end
        PH_AFTER_SUB: begin
          if (term) begin
            v = ST_ACCEPTED;
          end else if (cls == CLS_SEMI) begin
            phase_nxt = PH_NAME_LEAD;
          end else if (cls != CLS_SPACE) begin
            v = ST_ACCEPTED;
          end
        end
        PH_NAME_LEAD, PH_NAME: begin
          close_kind = KIND_NAME;
          put_kind   = KIND_NAME;
          if (phase_r == PH_NAME_LEAD && !term && cls == CLS_SPACE) begin
            phase_nxt = phase_r;
          end else if (term || cls == CLS_EQ) begin
            if (!nonempty_r) begin
              v = ST_EMPTY_NAME;
            end else if (term) begin
              v = ST_NO_EQUALS;
            end else begin
              close_en  = 1'b1;
              phase_nxt = PH_VAL_START;
            end
          end else if (cls != CLS_TOK) begin
            v = ST_BAD_NAME_CHAR;
          end else begin
            put_en    = 1'b1;
            phase_nxt = PH_NAME;
          end
        end
        PH_VAL_START, PH_TOKVAL: begin
          close_kind = KIND_VALUE;
          put_kind   = KIND_VALUE;
          put_char   = rd_item.raw;
          if (phase_r == PH_VAL_START && !term && cls == CLS_QUOTE) begin
            phase_nxt = PH_QUOTED;
          end else if (term || cls == CLS_SEMI || cls == CLS_SPACE) begin
            if (!nonempty_r) begin
              v = ST_EMPTY_VALUE;
            end else begin
              close_en = 1'b1;
              if (term) begin
                v = ST_ACCEPTED;
              end else begin
                phase_nxt = (cls == CLS_SEMI) ? PH_NAME_LEAD : PH_AFTER_VAL;
              end
            end
          end else if (cls != CLS_TOK) begin
            v = ST_BAD_VALUE_CHAR;
          end else begin
            put_en    = 1'b1;
            phase_nxt = PH_TOKVAL;
          end
        end
        PH_QUOTED: begin
          close_kind = KIND_VALUE;
          put_kind   = KIND_VALUE;
          put_char   = rd_item.raw;
          if (term) begin
            v = nonempty_r ? ST_OPEN_QUOTE : ST_EMPTY_VALUE;
          end else if (cls == CLS_QUOTE) begin
            if (!nonempty_r) begin
              v = ST_EMPTY_VALUE;
            end else begin
              close_en  = 1'b1;
              phase_nxt = PH_AFTER_VAL;
            end
          end else if (cls == CLS_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            put_en = 1'b1;
          end
        end
        PH_ESC: begin
          put_kind = KIND_VALUE;
          put_char = rd_item.raw;
          if (term) begin
            v = ST_TRUNC_ESC;
          end else if (cls == CLS_QUOTE || cls == CLS_BSLASH) begin
            put_en    = 1'b1;
            phase_nxt = PH_QUOTED;
          end else begin
            v = ST_BAD_ESC;
          end
        end
        PH_AFTER_VAL: begin
          if (term) begin
            v = ST_ACCEPTED;
          end else if (cls == CLS_SEMI) begin
            phase_nxt = PH_NAME_LEAD;
          end else if (cls != CLS_SPACE) begin
            v = ST_BAD_AFTER_VALUE;
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase
    end

    nonempty_nxt   = nonempty_r;
    out_char_nxt   = 8'h00;
    char_valid_nxt = 1'b0;
    kind_nxt       = KIND_TYPE;
    done_nxt       = 1'b0;
    if (put_en) begin
      out_char_nxt   = put_char;
      char_valid_nxt = 1'b1;
      kind_nxt       = put_kind;
      nonempty_nxt   = 1'b1;
    end
    if (close_en) begin
      done_nxt     = 1'b1;
      kind_nxt     = close_kind;
      nonempty_nxt = 1'b0;
    end
    status_nxt  = v;
    verdict_nxt = v;

    // terminator: report, then back to the reset state
    if (term) begin
      phase_nxt    = PH_TYPE;
      nonempty_nxt = 1'b0;
      verdict_nxt  = ST_PARSING;
    end

    if (rd_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      nonempty_r  <= 1'b0;
      verdict_r   <= ST_PARSING;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (rd_en) begin
        phase_r    <= phase_nxt;
        nonempty_r <= nonempty_nxt;
        verdict_r  <= verdict_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_char_r   <= out_char_nxt;
      char_valid_r <= char_valid_nxt;
      kind_r       <= kind_nxt;
      done_r       <= done_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_char   = out_char_r;
  assign out_ch.char_valid = char_valid_r;
  assign out_ch.token_kind = kind_r;
  assign out_ch.token_done = done_r;
  assign out_ch.status     = status_r;

endmodule

// ===== src/media_type_parser.sv =====
// top level of the media type parser: front end, item queue, back end
// depends on mtp_pkg, mtp_if, mtp_front, mtp_queue, mtp_back and assert_macros.svh
//
// Checks a media type string such as "text/html; charset=utf-8", one byte per
// item, and gives one result item per input item: the emitted token character
// (type, subtype and parameter name lowercased, values as written, quoted values
// unquoted and unescaped), the token kind, a token-end mark and a status that
// holds once a verdict is reached. A zero byte or a set is_end ends the string
// and returns the parser to its start state. One item per clock is sustained while
// the output is not stalled. The front end is combinational, so an accepted item
// is written into the queue, and the back end moves it from there into the output
// register. A two-entry queue absorbs input items while the output is stalled;
// input ready drops when the queue is full.
`include "assert_macros.svh"

module media_type_parser import mtp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mtp_in_if.sink    in_ch,
  mtp_out_if.source out_ch
);

  q_item_t wr_item;
  q_item_t rd_item;
  logic    wr_en;
  logic    rd_en;
  logic    q_valid;
  logic    q_full;

  mtp_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .wr_en   (wr_en),
    .wr_item (wr_item)
  );

  mtp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .rd_en   (rd_en),
    .rd_item (rd_item),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  mtp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .rd_item (rd_item),
    .rd_en   (rd_en),
    .out_ch  (out_ch)
  );

  `ASSERT_CLK(a_char_only_parsing, clk, rst_n,
              (out_ch.valid && out_ch.char_valid) |-> (out_ch.status == ST_PARSING),
              "character emitted after a verdict")
  `ASSERT_CLK(a_char_or_done, clk, rst_n,
              out_ch.valid |-> !(out_ch.char_valid && out_ch.token_done),
              "character and token end in one item")
  `ASSERT_CLK(a_pop_needs_room, clk, rst_n,
              rd_en |-> (!out_ch.valid || out_ch.ready),
              "queue popped into a held output")
  `ASSERT_NEXT(a_full_blocks_input, clk, rst_n,
               out_ch.valid && !out_ch.ready && q_full, !in_ch.ready,
               "input taken while queue full and output stalled")

endmodule
